@@ src/trm_pkg.sv @@
// Shared widths and constants of the transfer rate meter.
package trm_pkg;

  // Field widths
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned COUNT_W  = 48;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned RATE_W   = 56;
  localparam int unsigned IVAL_W   = 24;

  // Packed channel widths
  localparam int unsigned IN_DATA_W  = COUNT_W + TIME_W;
  localparam int unsigned OUT_DATA_W = 2 * RATE_W;

  // Default ring depth
  localparam int unsigned SLOT_COUNT_DEF = 8;

  // Interval register reset value (one second)
  localparam logic [IVAL_W-1:0] IVAL_RESET = 24'd1000000;

  // Rate scale: microseconds per second times 2^8 fraction steps
  localparam int unsigned        SCALE_W    = 28;
  localparam logic [SCALE_W-1:0] RATE_SCALE = 28'd256000000;

  // Divider geometry: dividend is a 48 x 28 bit product
  localparam int unsigned DIVIDEND_W = COUNT_W + SCALE_W;
  localparam int unsigned STEP_W     = 7;
  localparam int unsigned HALF_W     = COUNT_W / 2;

  // Commands
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_SAMPLE  = 1'b1;

endpackage

@@ src/transfer_rate_meter_unit.sv @@
// Top level of the transfer rate meter: sequencer, shared multiplier/divider and slot ring.
//
// Usage
//   Input requests arrive on in_t* (in_tuser = command, 0 restart, 1 sample;
//   in_tdata = byte count and microsecond timestamp). Each request yields one
//   result on out_t* (current ring-mean speed, average speed since restart,
//   and out_tuser set when the sample filled a new slot). Speeds are bytes per
//   second with 8 fraction bits. cfg_wr_en/cfg_wr_data set the minimum slot
//   interval in microseconds; write it only while the block is idle.
// Request flow
//   One request is in flight at a time; in_tready is low while it is worked.
//   A restart skips the divider. A sample divides for the average speed once time
//   has passed since restart; one that fills a slot first divides for the slot
//   speed and ring mean. Time goes to the bit-serial restoring divider (76 steps
//   per division) and to the one-read-port ring scan between those divisions.
// Reset and stall
//   rst_n low clears references, ring valid bits, the mean and the interval
//   (back to one second) and holds in_tready low. A finished result waits in
//   the output register while out_tready is low; the next request is accepted
//   meanwhile and its result waits until the register frees.
module transfer_rate_meter_unit
  import trm_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration
  input  logic                  cfg_wr_en,
  input  logic [IVAL_W-1:0]     cfg_wr_data,   // sample_interval_us
  // Input requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,      // [47:0] byte_count, [95:48] time_us
  input  logic                  in_tuser,      // [0] command
  // Results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,     // [55:0] current_speed, [111:56] average_speed
  output logic                  out_tuser      // [0] slot_written
);

  localparam int unsigned PTR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SUM_W = RATE_W + CNT_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECIDE    = 4'd1;
  localparam logic [3:0] S_MUL_LO    = 4'd2;
  localparam logic [3:0] S_MUL_HI    = 4'd3;
  localparam logic [3:0] S_DIV       = 4'd4;
  localparam logic [3:0] S_SUM       = 4'd5;
  localparam logic [3:0] S_MEAN      = 4'd6;
  localparam logic [3:0] S_AVG_SETUP = 4'd7;
  localparam logic [3:0] S_OUT       = 4'd8;

  // Division jobs
  localparam logic [1:0] OP_SLOT = 2'd0;
  localparam logic [1:0] OP_MEAN = 2'd1;
  localparam logic [1:0] OP_AVG  = 2'd2;

  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(DIVIDEND_W - 1);
  localparam logic [STEP_W-1:0] STEP_SAT   = STEP_W'(RATE_W);

  // Control state
  logic [3:0]            st_r, st_nxt;
  logic [1:0]            op_r;
  logic [IVAL_W-1:0]     ival_r;
  logic [COUNT_W-1:0]    ref_bytes_r, start_bytes_r;
  logic [TIME_W-1:0]     ref_time_r, start_time_r;
  logic [PTR_W-1:0]      ptr_r;
  logic [SLOT_COUNT-1:0] slot_vld_r;
  logic [RATE_W-1:0]     mean_r;
  logic [STEP_W-1:0]     step_r;
  logic [CNT_W-1:0]      k_r;
  logic                  rd_pend_r;
  logic                  rd_vld_r;
  logic                  out_valid_r;

  // Datapath registers
  logic                  cmd_r;
  logic [COUNT_W-1:0]    bytes_r, delta_r;
  logic [TIME_W-1:0]     now_r, dv_r;
  logic [DIVIDEND_W-1:0] num_r;
  logic [TIME_W-1:0]     rem_r;
  logic [RATE_W-1:0]     q_r;
  logic                  sat_r;
  logic [RATE_W-1:0]     avg_r;
  logic                  written_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [RATE_W-1:0]     rd_data_r;
  logic [RATE_W-1:0]     out_cur_r, out_avg_r;
  logic                  out_wr_r;

  logic [RATE_W-1:0]     slot_mem [SLOT_COUNT];

  // Combinational helpers
  logic                  in_acc;
  logic [TIME_W-1:0]     ival_eff;
  logic                  slot_due;
  logic                  last_step;
  logic [TIME_W:0]       rem_sh;
  logic                  ge;
  logic [TIME_W-1:0]     rem_nxt;
  logic [RATE_W-1:0]     q_nxt;
  logic                  sat_nxt;
  logic [RATE_W-1:0]     div_res;
  logic [HALF_W-1:0]     mul_a;
  logic [HALF_W+SCALE_W-1:0] prod;
  logic                  mem_we;
  logic                  k_live;
  logic [PTR_W-1:0]      rd_addr;
  logic                  acc_take;
  logic [SUM_W-1:0]      sum_nxt;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  out_free;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = rst_n && (st_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  // Interval of zero acts as one microsecond
  assign ival_eff = (ival_r == '0) ? TIME_W'(1) : TIME_W'(ival_r);
  assign slot_due = {1'b0, now_r} >= ({1'b0, ref_time_r} + {1'b0, ival_eff});

  // Shared multiplier: one 24 x 28 bit product per cycle
  assign mul_a = (st_r == S_MUL_LO) ? delta_r[HALF_W-1:0] : delta_r[COUNT_W-1:HALF_W];
  assign prod  = mul_a * RATE_SCALE;

  // Shared restoring divider step
  assign last_step = (step_r == '0);
  assign rem_sh    = {rem_r, num_r[DIVIDEND_W-1]};
  assign ge        = rem_sh >= {1'b0, dv_r};
  assign rem_nxt   = ge ? TIME_W'(rem_sh - {1'b0, dv_r}) : rem_sh[TIME_W-1:0];
  assign q_nxt     = {q_r[RATE_W-2:0], ge};
  assign sat_nxt   = sat_r || (ge && (step_r >= STEP_SAT));
  assign div_res   = sat_nxt ? {RATE_W{1'b1}} : q_nxt;

  assign mem_we = (st_r == S_DIV) && last_step && (op_r == OP_SLOT);

  // Ring scan: one read address per cycle, read data registered for the cycle after
  assign k_live   = (k_r < CNT_W'(SLOT_COUNT));
  assign rd_addr  = k_live ? k_r[PTR_W-1:0] : '0;
  assign acc_take = rd_pend_r && rd_vld_r && (rd_data_r != '0);
  assign sum_nxt  = acc_take ? sum_r + SUM_W'(rd_data_r) : sum_r;
  assign cnt_nxt  = acc_take ? cnt_r + CNT_W'(1) : cnt_r;

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_acc) st_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (cmd_r == CMD_SAMPLE && slot_due) st_nxt = S_MUL_LO;
        else st_nxt = S_AVG_SETUP;
      end
      S_MUL_LO: st_nxt = S_MUL_HI;
      S_MUL_HI: st_nxt = S_DIV;
      S_DIV: begin
        if (last_step) begin
          case (op_r)
            OP_SLOT: st_nxt = S_SUM;
            OP_MEAN: st_nxt = S_AVG_SETUP;
            default: st_nxt = S_OUT;
          endcase
        end
      end
      S_SUM: begin
        if (!k_live) st_nxt = S_MEAN;
      end
      S_MEAN: begin
        if (cnt_r == '0) st_nxt = S_AVG_SETUP;
        else st_nxt = S_DIV;
      end
      S_AVG_SETUP: begin
        if (now_r > start_time_r) st_nxt = S_MUL_LO;
        else st_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      op_r          <= OP_SLOT;
      ival_r        <= IVAL_RESET;
      ref_bytes_r   <= '0;
      ref_time_r    <= '0;
      start_bytes_r <= '0;
      start_time_r  <= '0;
      ptr_r         <= '0;
      slot_vld_r    <= '0;
      mean_r        <= '0;
      step_r        <= '0;
      k_r           <= '0;
      rd_pend_r     <= 1'b0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      rd_pend_r <= (st_r == S_SUM) && k_live;
      rd_vld_r  <= slot_vld_r[rd_addr];

      if (cfg_wr_en) ival_r <= cfg_wr_data;

      // Fill the result register when done, release it once taken
      if (st_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      case (st_r)
        S_DECIDE: begin
          if (cmd_r == CMD_RESTART) begin
            ref_bytes_r   <= bytes_r;
            ref_time_r    <= now_r;
            start_bytes_r <= bytes_r;
            start_time_r  <= now_r;
            ptr_r         <= '0;
            slot_vld_r    <= '0;
            mean_r        <= '0;
          end else if (slot_due) begin
            ptr_r <= (ptr_r == PTR_W'(SLOT_COUNT - 1)) ? '0 : ptr_r + PTR_W'(1);
            op_r  <= OP_SLOT;
          end
        end
        S_MUL_HI: step_r <= STEP_FIRST;
        S_DIV: begin
          step_r <= step_r - STEP_W'(1);
          if (last_step) begin
            case (op_r)
              OP_SLOT: begin
                slot_vld_r[ptr_r] <= 1'b1;
                ref_bytes_r       <= bytes_r;
                ref_time_r        <= now_r;
                k_r               <= '0;
              end
              OP_MEAN: mean_r <= div_res;
              default: ;
            endcase
          end
        end
        S_SUM: begin
          if (k_live) k_r <= k_r + CNT_W'(1);
        end
        S_MEAN: begin
          if (cnt_r == '0) mean_r <= '0;
          op_r   <= OP_MEAN;
          step_r <= STEP_FIRST;
        end
        S_AVG_SETUP: op_r <= OP_AVG;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_tuser;
      bytes_r <= in_tdata[COUNT_W-1:0];
      now_r   <= in_tdata[IN_DATA_W-1:COUNT_W];
    end

    case (st_r)
      S_IDLE: written_r <= 1'b0;
      S_DECIDE: begin
        avg_r <= '0;
        if (cmd_r == CMD_SAMPLE && slot_due) begin
          delta_r <= (bytes_r > ref_bytes_r) ? bytes_r - ref_bytes_r : '0;
          dv_r    <= now_r - ref_time_r;
        end
      end
      S_MUL_LO: num_r <= DIVIDEND_W'(prod);
      S_MUL_HI: begin
        num_r <= num_r + (DIVIDEND_W'(prod) << HALF_W);
        rem_r <= '0;
        q_r   <= '0;
        sat_r <= 1'b0;
      end
      S_DIV: begin
        num_r <= num_r << 1;
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        sat_r <= sat_nxt;
        if (last_step) begin
          if (op_r == OP_SLOT) begin
            written_r <= 1'b1;
            sum_r     <= '0;
            cnt_r     <= '0;
          end else if (op_r == OP_AVG) begin
            avg_r <= div_res;
          end
        end
      end
      S_SUM: begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
      S_MEAN: begin
        num_r <= DIVIDEND_W'(sum_r);
        dv_r  <= TIME_W'(cnt_r);
        rem_r <= '0;
        q_r   <= '0;
        sat_r <= 1'b0;
      end
      S_AVG_SETUP: begin
        delta_r <= (bytes_r > start_bytes_r) ? bytes_r - start_bytes_r : '0;
        dv_r    <= now_r - start_time_r;
      end
      S_OUT: begin
        if (out_free) begin
          out_cur_r <= mean_r;
          out_avg_r <= avg_r;
          out_wr_r  <= written_r;
        end
      end
      default: ;
    endcase
  end

  // Slot ring storage
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[ptr_r] <= div_res;
    rd_data_r <= slot_mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_avg_r, out_cur_r};
  assign out_tuser  = out_wr_r;

endmodule

@@ src/trm_checker.sv @@
// Port-level checks of the transfer rate meter, bound to the top level.
module trm_checker
  import trm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  // After a request is accepted, in_tready stays low while the block is busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("request accepted while previous one still in work");

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A restart result shows zero speeds and no slot fill
  a_restart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_RESTART && !out_tvalid)
      |-> ##4 (out_tvalid && out_tdata == '0 && !out_tuser))
    else $error("restart result not zero");

endmodule

bind transfer_rate_meter_unit trm_checker u_trm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
